[rtl/fsv_pkg.sv]
// types, codes and reset constants shared by the flight safety supervisor
`timescale 1ns / 1ps
`default_nettype none

package fsv_pkg;

   // item kinds on the request channel
   typedef enum logic [1:0] {
      ACT_SAMPLE  = 2'd0,
      ACT_COMMAND = 2'd1,
      ACT_ARM     = 2'd2,
      ACT_UNUSED  = 2'd3
   } action_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_ARM_FAIL = 3'd1,
      ST_ATTITUDE = 3'd2,
      ST_LOST     = 3'd3,
      ST_STALL    = 3'd4,
      ST_LOW_BAT  = 3'd5
   } status_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CFG_ANGLE_LIMIT    = 3'd0,
      CFG_BATTERY_THRESH = 3'd1,
      CFG_CMD_TIMEOUT    = 3'd2,
      CFG_STALL_MOTOR    = 3'd3,
      CFG_ARM_MOTOR      = 3'd4,
      CFG_ATT_DWELL      = 3'd5,
      CFG_STALL_DWELL    = 3'd6,
      CFG_BAT_DWELL      = 3'd7
   } cfg_index_type;

   localparam int CSR_DATA_BITS = 32;

   typedef struct packed {
      logic [14:0] angle_limit;
      logic [15:0] battery_threshold_mv;
      logic [31:0] command_timeout_ms;
      logic [11:0] stall_motor_threshold;
      logic [11:0] arm_motor_threshold;
      logic [15:0] attitude_dwell_ms;
      logic [15:0] stall_dwell_ms;
      logic [15:0] battery_dwell_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      angle_limit:           15'd4289,
      battery_threshold_mv:  16'd6400,
      command_timeout_ms:    32'd1000,
      stall_motor_threshold: 12'd3686,
      arm_motor_threshold:   12'd410,
      attitude_dwell_ms:     16'd200,
      stall_dwell_ms:        16'd3000,
      battery_dwell_ms:      16'd500
   };

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic [11:0]        motor_one;
      logic [11:0]        motor_two;
      logic [11:0]        motor_three;
      logic [11:0]        motor_four;
      logic [15:0]        battery_mv;
      logic [31:0]        now_ms;
      logic               arm_value;
   } item_type;

   typedef struct packed {
      logic [2:0] status;
      logic       armed_now;
   } result_type;

   // 0.0175 rad in Q3.12 is 71.68: a move below 72 counts as none
   localparam logic [17:0] STALL_MOVE_LIMIT = 18'd72;
   // battery counts as measured above 0.1 V
   localparam logic [15:0] BATTERY_MEASURED_MV = 16'd100;

endpackage

`default_nettype wire

[rtl/fsv_ifs.sv]
// request, response and register write channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface fsv_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [15:0] roll;
   logic signed [15:0] pitch;
   logic [11:0]        motor_one;
   logic [11:0]        motor_two;
   logic [11:0]        motor_three;
   logic [11:0]        motor_four;
   logic [15:0]        battery_mv;
   logic [31:0]        now_ms;
   logic               arm_value;

   modport source (
      output valid, action, roll, pitch, motor_one, motor_two, motor_three,
             motor_four, battery_mv, now_ms, arm_value,
      input  ready
   );
   modport sink (
      input  valid, action, roll, pitch, motor_one, motor_two, motor_three,
             motor_four, battery_mv, now_ms, arm_value,
      output ready
   );
endinterface

interface fsv_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic       armed_now;

   modport source (output valid, status, armed_now, input ready);
   modport sink (input valid, status, armed_now, output ready);
endinterface

interface fsv_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

[rtl/fsv_cfg_regs.sv]
// configuration register file
`timescale 1ns / 1ps
`default_nettype none

module fsv_cfg_regs
   import fsv_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     wr_en,
   input  wire logic [2:0]               wr_index,
   input  wire logic [CSR_DATA_BITS-1:0] wr_data,
   output cfg_type                       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (cfg_index_type'(wr_index))
            CFG_ANGLE_LIMIT:    cfg_in.angle_limit           = wr_data[14:0];
            CFG_BATTERY_THRESH: cfg_in.battery_threshold_mv  = wr_data[15:0];
            CFG_CMD_TIMEOUT:    cfg_in.command_timeout_ms    = wr_data[31:0];
            CFG_STALL_MOTOR:    cfg_in.stall_motor_threshold = wr_data[11:0];
            CFG_ARM_MOTOR:      cfg_in.arm_motor_threshold   = wr_data[11:0];
            CFG_ATT_DWELL:      cfg_in.attitude_dwell_ms     = wr_data[15:0];
            CFG_STALL_DWELL:    cfg_in.stall_dwell_ms        = wr_data[15:0];
            CFG_BAT_DWELL:      cfg_in.battery_dwell_ms      = wr_data[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/fsv_check_core.sv]
// supervisor state and the prioritized sample checks
`timescale 1ns / 1ps
`default_nettype none

module fsv_check_core
   import fsv_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic step,
   input  item_type  item,
   input  cfg_type   cfg,
   output result_type result,
   output logic      armed
);

   localparam int WIDE_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

   logic                 armed_ff, armed_in;
   status_type           status_ff, status_in;
   logic [TIME_BITS-1:0] cmd_time_ff, cmd_time_in;
   logic [TIME_BITS-1:0] att_start_ff, att_start_in;
   logic [TIME_BITS-1:0] stall_start_ff, stall_start_in;
   logic [TIME_BITS-1:0] bat_start_ff, bat_start_in;
   logic signed [15:0]   roll_ref_ff, roll_ref_in;
   logic signed [15:0]   pitch_ref_ff, pitch_ref_in;

   logic [WIDE_BITS-1:0] now_wide;
   logic [TIME_BITS-1:0] now_t;
   logic [11:0]          max_a, max_b, mmax;
   logic signed [16:0]   roll_x, pitch_x;
   logic [16:0]          roll_abs, pitch_abs;
   logic signed [17:0]   roll_d, pitch_d;
   logic [17:0]          roll_d_abs, pitch_d_abs;
   logic [TIME_BITS-1:0] el_att, el_cmd, el_stall, el_bat;
   logic                 arm_fail, att_over, att_fault, lost_fault;
   logic                 stall_reach, stall_hot, stall_due, still, stall_fault;
   logic                 bat_reach, bat_low, bat_fault;
   status_type           check_status;

   always_comb begin
      now_wide = WIDE_BITS'(item.now_ms);
      now_t    = now_wide[TIME_BITS-1:0];

      max_a = (item.motor_one > item.motor_two) ? item.motor_one : item.motor_two;
      max_b = (item.motor_three > item.motor_four) ? item.motor_three : item.motor_four;
      mmax  = (max_a > max_b) ? max_a : max_b;

      roll_x    = 17'(item.roll);
      pitch_x   = 17'(item.pitch);
      roll_abs  = roll_x[16] ? 17'(-roll_x) : 17'(roll_x);
      pitch_abs = pitch_x[16] ? 17'(-pitch_x) : 17'(pitch_x);

      roll_d      = 18'(item.roll) - 18'(roll_ref_ff);
      pitch_d     = 18'(item.pitch) - 18'(pitch_ref_ff);
      roll_d_abs  = roll_d[17] ? 18'(-roll_d) : 18'(roll_d);
      pitch_d_abs = pitch_d[17] ? 18'(-pitch_d) : 18'(pitch_d);

      // wrapping elapsed times
      el_att   = now_t - att_start_ff;
      el_cmd   = now_t - cmd_time_ff;
      el_stall = now_t - stall_start_ff;
      el_bat   = now_t - bat_start_ff;

      arm_fail = !armed_ff && (mmax > cfg.arm_motor_threshold);

      att_over  = (roll_abs > 17'(cfg.angle_limit)) || (pitch_abs > 17'(cfg.angle_limit));
      att_fault = !arm_fail && att_over && (att_start_ff != '0)
                  && (el_att > TIME_BITS'(cfg.attitude_dwell_ms));

      lost_fault = !arm_fail && !att_fault && armed_ff
                   && (WIDE_BITS'(el_cmd) > WIDE_BITS'(cfg.command_timeout_ms));

      stall_reach = !arm_fail && !att_fault && !lost_fault;
      stall_hot   = mmax > cfg.stall_motor_threshold;
      stall_due   = (stall_start_ff != '0) && (el_stall > TIME_BITS'(cfg.stall_dwell_ms));
      still       = (roll_d_abs < STALL_MOVE_LIMIT) && (pitch_d_abs < STALL_MOVE_LIMIT);
      stall_fault = stall_reach && stall_hot && stall_due && still;

      bat_reach = stall_reach && !stall_fault;
      bat_low   = (item.battery_mv > BATTERY_MEASURED_MV)
                  && (item.battery_mv < cfg.battery_threshold_mv);
      bat_fault = bat_reach && bat_low && (bat_start_ff != '0)
                  && (el_bat > TIME_BITS'(cfg.battery_dwell_ms));

      if (arm_fail) begin
         check_status = ST_ARM_FAIL;
      end else if (att_fault) begin
         check_status = ST_ATTITUDE;
      end else if (lost_fault) begin
         check_status = ST_LOST;
      end else if (stall_fault) begin
         check_status = ST_STALL;
      end else if (bat_fault) begin
         check_status = ST_LOW_BAT;
      end else begin
         check_status = ST_OK;
      end
   end

   always_comb begin
      armed_in       = armed_ff;
      status_in      = status_ff;
      cmd_time_in    = cmd_time_ff;
      att_start_in   = att_start_ff;
      stall_start_in = stall_start_ff;
      bat_start_in   = bat_start_ff;
      roll_ref_in    = roll_ref_ff;
      pitch_ref_in   = pitch_ref_ff;
      if (step) begin
         unique case (action_type'(item.action))
            ACT_SAMPLE: begin
               status_in = check_status;
               // attitude timer, touched unless arm fail stopped the pass
               if (!arm_fail) begin
                  if (!att_over) begin
                     att_start_in = '0;
                  end else if (att_start_ff == '0) begin
                     att_start_in = now_t;
                  end
               end
               // stall window: start, restart on movement, or drop
               if (stall_reach) begin
                  if (!stall_hot) begin
                     stall_start_in = '0;
                  end else if ((stall_start_ff == '0) || (stall_due && !still)) begin
                     stall_start_in = now_t;
                     roll_ref_in    = item.roll;
                     pitch_ref_in   = item.pitch;
                  end
               end
               if (bat_reach) begin
                  if (!bat_low) begin
                     bat_start_in = '0;
                  end else if (bat_start_ff == '0) begin
                     bat_start_in = now_t;
                  end
               end
            end
            ACT_COMMAND: cmd_time_in = now_t;
            ACT_ARM:     armed_in    = item.arm_value;
            default:     armed_in    = armed_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff       <= 1'b0;
         status_ff      <= ST_OK;
         cmd_time_ff    <= '0;
         att_start_ff   <= '0;
         stall_start_ff <= '0;
         bat_start_ff   <= '0;
         roll_ref_ff    <= '0;
         pitch_ref_ff   <= '0;
      end else begin
         armed_ff       <= armed_in;
         status_ff      <= status_in;
         cmd_time_ff    <= cmd_time_in;
         att_start_ff   <= att_start_in;
         stall_start_ff <= stall_start_in;
         bat_start_ff   <= bat_start_in;
         roll_ref_ff    <= roll_ref_in;
         pitch_ref_ff   <= pitch_ref_in;
      end
   end

   assign result.status    = status_in;
   assign result.armed_now = armed_in;
   assign armed            = armed_ff;

endmodule

`default_nettype wire

[rtl/flight_safety_supervisor_top.sv]
// flight safety supervisor top level: input register, check core, result register
// a request beat passes the input register, then the result register, before it shows up as a response beat
// throughput: one beat per cycle while the response side takes beats, the check core finishes a sample in one pass
// a stalled response holds the input register, which then holds off new requests
// reset (synchronous): disarmed, status ok, timers idle, config at defaults, no beats held
`timescale 1ns / 1ps
`default_nettype none

module flight_safety_supervisor_top
   import fsv_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   fsv_req_if.sink    req_bus,
   fsv_rsp_if.source  rsp_bus,
   fsv_csr_if.sink    csr_bus
);

   // pipeline control
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_item_ff, rsp_item_in;
   logic       advance;   // result register can take a new value
   logic       load;      // input register hands its item to the core
   logic       req_take;

   cfg_type    cfg;
   result_type core_result;
   logic       core_armed;

   // config writes are taken at once
   assign csr_bus.ready = 1'b1;

   fsv_cfg_regs u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.wdata),
      .cfg      (cfg)
   );

   // handshake: the input register frees up whenever its item moves on
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign load          = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_item_in = in_item_ff;
      if (req_take) begin
         in_item_in.action      = req_bus.action;
         in_item_in.roll        = req_bus.roll;
         in_item_in.pitch       = req_bus.pitch;
         in_item_in.motor_one   = req_bus.motor_one;
         in_item_in.motor_two   = req_bus.motor_two;
         in_item_in.motor_three = req_bus.motor_three;
         in_item_in.motor_four  = req_bus.motor_four;
         in_item_in.battery_mv  = req_bus.battery_mv;
         in_item_in.now_ms      = req_bus.now_ms;
         in_item_in.arm_value   = req_bus.arm_value;
      end
      in_valid_in  = req_take || (in_valid_ff && !advance);
      rsp_valid_in = load || (rsp_valid_ff && !rsp_bus.ready);
      rsp_item_in  = load ? core_result : rsp_item_ff;
   end

   // check core updates its state only on the load cycle
   fsv_check_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (load),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result),
      .armed  (core_armed)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_item_ff.status;
   assign rsp_bus.armed_now = rsp_item_ff.armed_now;

   // a held input item must not change while the result side is stalled
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("input register changed while stalled");

   // the armed flag in a result beat matches the core state after the step
   a_armed_match: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_item_ff.armed_now == core_armed)
      else $error("result armed flag differs from core state");

   // a response register loads only from a held input item
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(in_valid_ff))
      else $error("response beat appeared without an input item");

   // nothing is held right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !in_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

[verif/testbench.sv]
// self-checking testbench for the flight safety supervisor top level
`timescale 1ns / 1ps

module testbench;
   import fsv_pkg::*;

   // scoreboard: tracks the supervisor's state and config, queues expected result beats
   class safety_scoreboard;
      localparam int STILL_BOUND = 72;         // 0.0175 rad in Q3.12, rounded up
      localparam int MEASURED_FLOOR_MV = 100;  // battery reads as present above 0.1 V

      cfg_type     cfg;
      logic        armed;
      status_type  status;
      logic [31:0] last_cmd;
      logic [31:0] att_start;
      logic [31:0] stall_start;
      logic [31:0] bat_start;
      int          roll_ref;
      int          pitch_ref;
      result_type  expected[$];
      int          errors;

      function new();
         cfg = CFG_RESET;
         armed = 1'b0;
         status = ST_OK;
         last_cmd = '0;
         att_start = '0;
         stall_start = '0;
         bat_start = '0;
         roll_ref = 0;
         pitch_ref = 0;
         errors = 0;
      endfunction

      function void write_reg(cfg_index_type idx, logic [31:0] data);
         case (idx)
            CFG_ANGLE_LIMIT:    cfg.angle_limit = data[14:0];
            CFG_BATTERY_THRESH: cfg.battery_threshold_mv = data[15:0];
            CFG_CMD_TIMEOUT:    cfg.command_timeout_ms = data;
            CFG_STALL_MOTOR:    cfg.stall_motor_threshold = data[11:0];
            CFG_ARM_MOTOR:      cfg.arm_motor_threshold = data[11:0];
            CFG_ATT_DWELL:      cfg.attitude_dwell_ms = data[15:0];
            CFG_STALL_DWELL:    cfg.stall_dwell_ms = data[15:0];
            CFG_BAT_DWELL:      cfg.battery_dwell_ms = data[15:0];
            default: ;
         endcase
      endfunction

      function int magnitude(int v);
         return (v < 0) ? -v : v;
      endfunction

      // prioritized checks on one sample, first fault wins
      function status_type evaluate_sample(item_type it);
         int          roll_v;
         int          pitch_v;
         logic [11:0] peak;
         logic [31:0] now;
         roll_v = int'($signed(it.roll));
         pitch_v = int'($signed(it.pitch));
         now = it.now_ms;
         peak = it.motor_one;
         if (it.motor_two > peak) peak = it.motor_two;
         if (it.motor_three > peak) peak = it.motor_three;
         if (it.motor_four > peak) peak = it.motor_four;

         if (!armed && peak > cfg.arm_motor_threshold)
            return ST_ARM_FAIL;

         if (magnitude(roll_v) > int'(cfg.angle_limit) ||
             magnitude(pitch_v) > int'(cfg.angle_limit)) begin
            if (att_start == 0)
               att_start = now;
            else if (32'(now - att_start) > 32'(cfg.attitude_dwell_ms))
               return ST_ATTITUDE;
         end else begin
            att_start = '0;
         end

         if (armed && 32'(now - last_cmd) > cfg.command_timeout_ms)
            return ST_LOST;

         if (peak > cfg.stall_motor_threshold) begin
            if (stall_start == 0) begin
               stall_start = now;
               roll_ref = roll_v;
               pitch_ref = pitch_v;
            end else if (32'(now - stall_start) > 32'(cfg.stall_dwell_ms)) begin
               if (magnitude(roll_v - roll_ref) < STILL_BOUND &&
                   magnitude(pitch_v - pitch_ref) < STILL_BOUND)
                  return ST_STALL;
               stall_start = now;
               roll_ref = roll_v;
               pitch_ref = pitch_v;
            end
         end else begin
            stall_start = '0;
         end

         if (int'(it.battery_mv) > MEASURED_FLOOR_MV &&
             it.battery_mv < cfg.battery_threshold_mv) begin
            if (bat_start == 0)
               bat_start = now;
            else if (32'(now - bat_start) > 32'(cfg.battery_dwell_ms))
               return ST_LOW_BAT;
         end else begin
            bat_start = '0;
         end

         return ST_OK;
      endfunction

      function void note_input(item_type it);
         result_type r;
         case (it.action)
            ACT_SAMPLE:  status = evaluate_sample(it);
            ACT_COMMAND: last_cmd = it.now_ms;
            ACT_ARM:     armed = it.arm_value;
            default: ;
         endcase
         r.status = status;
         r.armed_now = armed;
         expected.push_back(r);
      endfunction

      function void check_result(logic [2:0] got_status, logic got_armed);
         result_type want;
         if (expected.size() == 0) begin
            $display("%0t: unexpected response beat: status %0d armed %0d",
                     $time, got_status, got_armed);
            errors++;
            return;
         end
         want = expected.pop_front();
         if (got_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, got_status);
            errors++;
         end
         if (got_armed !== want.armed_now) begin
            $display("%0t: armed_now mismatch: expected %0d actual %0d",
                     $time, want.armed_now, got_armed);
            errors++;
         end
      endfunction

      function int pending();
         return expected.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   fsv_req_if req_bus();
   fsv_rsp_if rsp_bus();
   fsv_csr_if csr_bus();

   flight_safety_supervisor_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   safety_scoreboard sb = new();

   // idle bursts on both channels are enabled per phase
   bit          idle_bursts;
   // stimulus generator state: running time base and sticky field modes
   logic [31:0] time_ms;
   int          step_max;
   int          run_left;
   int          motor_mode;
   int          angle_mode;
   int          bat_mode;
   int          roll_base;
   int          pitch_base;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on the whole run
   initial begin
      #5_000_000;
      $display("testbench failed");
      $finish;
   end

   // response side: ready drops in random bursts while idling is on
   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_bus.ready = 1'b0;
         end else if (idle_bursts && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(0, 15);
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // monitor: note request beats first, then check response beats
   always @(posedge clock) begin
      item_type seen;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen.action = req_bus.action;
            seen.roll = req_bus.roll;
            seen.pitch = req_bus.pitch;
            seen.motor_one = req_bus.motor_one;
            seen.motor_two = req_bus.motor_two;
            seen.motor_three = req_bus.motor_three;
            seen.motor_four = req_bus.motor_four;
            seen.battery_mv = req_bus.battery_mv;
            seen.now_ms = req_bus.now_ms;
            seen.arm_value = req_bus.arm_value;
            sb.note_input(seen);
         end
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.status, rsp_bus.armed_now);
      end
   end

   // uniform int in [lo, hi], lo when the range is empty
   function automatic int pick(int lo, int hi);
      if (hi <= lo) return lo;
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic item_type make_item(action_type act, int roll, int pitch,
                                          int m1, int m2, int m3, int m4, int bat,
                                          logic [31:0] now, logic arm);
      item_type it;
      it.action = act;
      it.roll = 16'(roll);
      it.pitch = 16'(pitch);
      it.motor_one = 12'(m1);
      it.motor_two = 12'(m2);
      it.motor_three = 12'(m3);
      it.motor_four = 12'(m4);
      it.battery_mv = 16'(bat);
      it.now_ms = now;
      it.arm_value = arm;
      return it;
   endfunction

   // random item: fields keep a mode for a run of beats so dwell timers get to expire
   function item_type next_random_item();
      item_type     it;
      logic [159:0] noise;
      int           roll;
      int           pitch;
      int           m[4];
      int           thr;
      int           lim;
      int           sel;
      int           r;
      action_type   act;

      if (run_left == 0) begin
         run_left = pick(1, 24);
         motor_mode = pick(0, 3);
         angle_mode = pick(0, 3);
         bat_mode = pick(0, 3);
         roll_base = pick(-32767, 32767);
         pitch_base = pick(-32767, 32767);
      end
      run_left--;

      // time base: mostly small forward steps, sometimes zero, wrap or jump
      r = pick(0, 99);
      if (r < 2)
         time_ms = $urandom;
      else if (r < 4)
         time_ms = 32'hFFFF_FFFF - 32'(pick(0, step_max * 4));
      else if (r < 5)
         time_ms = '0;
      else
         time_ms += 32'(pick(0, step_max));

      // noise beat: every field random
      if (pick(0, 19) == 0) begin
         noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
         it = noise[$bits(item_type)-1:0];
         if (it.roll == 16'h8000) it.roll = 16'h8001;
         if (it.pitch == 16'h8000) it.pitch = 16'h8001;
         return it;
      end

      r = pick(0, 99);
      if (r < 68) act = ACT_SAMPLE;
      else if (r < 83) act = ACT_COMMAND;
      else if (r < 96) act = ACT_ARM;
      else act = ACT_UNUSED;

      case (motor_mode)
         0: begin
            thr = int'(sb.cfg.arm_motor_threshold);
            foreach (m[i]) m[i] = pick(0, thr);
         end
         1: begin
            thr = int'(sb.cfg.stall_motor_threshold);
            foreach (m[i]) m[i] = pick(0, thr);
            m[pick(0, 3)] = clamp(thr + pick(-3, 3), 0, 4095);
         end
         2: foreach (m[i]) m[i] = pick(0, 4095);
         default: begin
            foreach (m[i]) m[i] = pick(4090, 4095);
            m[pick(0, 3)] = 4095;
         end
      endcase

      case (angle_mode)
         0: begin
            // near-still around a base, straddling the stall movement bound
            roll = clamp(roll_base + pick(-75, 75), -32767, 32767);
            pitch = clamp(pitch_base + pick(-75, 75), -32767, 32767);
         end
         1: begin
            lim = int'(sb.cfg.angle_limit);
            sel = clamp(lim + pick(-2, 2), 0, 32767);
            roll = pick(-200, 200);
            pitch = pick(-200, 200);
            if (pick(0, 1) == 0) roll = pick(0, 1) ? sel : -sel;
            else pitch = pick(0, 1) ? sel : -sel;
         end
         2: begin
            roll = pick(-32767, 32767);
            pitch = pick(-32767, 32767);
         end
         default: begin
            sel = pick(0, 2);
            roll = (sel == 0) ? -32767 : ((sel == 1) ? 32767 : 0);
            sel = pick(0, 2);
            pitch = (sel == 0) ? -32767 : ((sel == 1) ? 32767 : 0);
         end
      endcase

      thr = int'(sb.cfg.battery_threshold_mv);
      case (bat_mode)
         0: sel = pick(0, 102);
         1: sel = clamp(thr + pick(-2, 2), 0, 65535);
         2: sel = pick(101, thr);
         default: sel = pick(0, 65535);
      endcase

      it = make_item(act, roll, pitch, m[0], m[1], m[2], m[3], sel, time_ms,
                     logic'(pick(0, 9) < 7));
      return it;
   endfunction

   // one request beat; optional idle burst before it
   task automatic send_item(item_type it);
      int gap;
      if (idle_bursts && pick(0, 7) == 0) begin
         gap = pick(1, 16);
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.action = it.action;
      req_bus.roll = it.roll;
      req_bus.pitch = it.pitch;
      req_bus.motor_one = it.motor_one;
      req_bus.motor_two = it.motor_two;
      req_bus.motor_three = it.motor_three;
      req_bus.motor_four = it.motor_four;
      req_bus.battery_mv = it.battery_mv;
      req_bus.now_ms = it.now_ms;
      req_bus.arm_value = it.arm_value;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic write_csr(cfg_index_type idx, logic [31:0] data);
      @(negedge clock);
      req_bus.valid = 1'b0;
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.wdata = data;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic apply_settings(logic [31:0] angle, logic [31:0] batt,
                                 logic [31:0] timeout, logic [31:0] stall_level,
                                 logic [31:0] arm_level, logic [31:0] att_dwell,
                                 logic [31:0] stall_dwell, logic [31:0] bat_dwell);
      write_csr(CFG_ANGLE_LIMIT, angle);
      write_csr(CFG_BATTERY_THRESH, batt);
      write_csr(CFG_CMD_TIMEOUT, timeout);
      write_csr(CFG_STALL_MOTOR, stall_level);
      write_csr(CFG_ARM_MOTOR, arm_level);
      write_csr(CFG_ATT_DWELL, att_dwell);
      write_csr(CFG_STALL_DWELL, stall_dwell);
      write_csr(CFG_BAT_DWELL, bat_dwell);
   endtask

   // wait for every expected beat, then let the two-stage pipe settle
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(int count, int step, bit bursts);
      idle_bursts = bursts;
      step_max = step;
      run_left = 0;
      repeat (count) send_item(next_random_item());
      wait_drained();
   endtask

   initial begin
      item_type directed[$];

      reset = 1'b1;
      idle_bursts = 1'b0;
      time_ms = '0;
      step_max = 1;
      run_left = 0;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_SAMPLE;
      req_bus.roll = '0;
      req_bus.pitch = '0;
      req_bus.motor_one = '0;
      req_bus.motor_two = '0;
      req_bus.motor_three = '0;
      req_bus.motor_four = '0;
      req_bus.battery_mv = '0;
      req_bus.now_ms = '0;
      req_bus.arm_value = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CFG_ANGLE_LIMIT;
      csr_bus.wdata = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed beats at the reset config
      // sample at time zero: timers that start here stay idle
      directed.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 32'd0, 1'b0));
      // unused action code with every field at its extreme is ignored
      directed.push_back(make_item(ACT_UNUSED, -32767, 32767, 4095, 4095, 4095, 4095,
                                   65535, 32'hFFFF_FFFF, 1'b1));
      // disarmed with a motor spinning: arm fail, then exactly at threshold: ok
      directed.push_back(make_item(ACT_SAMPLE, 0, 0, 4095, 0, 0, 0, 7000, 32'd5, 1'b0));
      directed.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 0, 0, 410, 7000, 32'd6, 1'b0));
      directed.push_back(make_item(ACT_ARM, 0, 0, 0, 0, 0, 0, 0, 32'd10, 1'b1));
      directed.push_back(make_item(ACT_COMMAND, 0, 0, 0, 0, 0, 0, 0, 32'd20, 1'b0));
      // attitude over limit: start, at the dwell, past the dwell
      directed.push_back(make_item(ACT_SAMPLE, 4290, 0, 0, 0, 0, 0, 7000, 32'd30, 1'b0));
      directed.push_back(make_item(ACT_SAMPLE, 0, -4290, 0, 0, 0, 0, 7000, 32'd230, 1'b0));
      directed.push_back(make_item(ACT_SAMPLE, -32767, 0, 0, 0, 0, 0, 7000, 32'd231,
                                   1'b0));
      // command timeout while armed
      directed.push_back(make_item(ACT_COMMAND, 0, 0, 0, 0, 0, 0, 0, 32'd1000, 1'b0));
      directed.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 7000, 32'd2001, 1'b0));
      directed.push_back(make_item(ACT_COMMAND, 0, 0, 0, 0, 0, 0, 0, 32'd2001, 1'b0));
      // high throttle with moves just under the bound: the command timeout wins over the stall
      directed.push_back(make_item(ACT_SAMPLE, 100, 100, 3687, 0, 0, 0, 7000, 32'd2100,
                                   1'b0));
      directed.push_back(make_item(ACT_COMMAND, 0, 0, 0, 0, 0, 0, 0, 32'd2600, 1'b0));
      directed.push_back(make_item(ACT_COMMAND, 0, 0, 0, 0, 0, 0, 0, 32'd3100, 1'b0));
      directed.push_back(make_item(ACT_SAMPLE, 171, 29, 0, 4095, 0, 0, 7000, 32'd5101,
                                   1'b0));
      directed.push_back(make_item(ACT_COMMAND, 0, 0, 0, 0, 0, 0, 0, 32'd5200, 1'b0));
      // window ends with movement: window restarts with new references
      directed.push_back(make_item(ACT_SAMPLE, 172, 100, 0, 0, 4095, 0, 7000, 32'd5300,
                                   1'b0));
      // low battery: start, past dwell, then unmeasured clears it
      directed.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 101, 32'd5400, 1'b0));
      directed.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 6399, 32'd5901, 1'b0));
      directed.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 100, 32'd5950, 1'b0));
      // disarm, then a low battery dwell across the time wrap
      directed.push_back(make_item(ACT_ARM, 0, 0, 0, 0, 0, 0, 0, 32'd5960, 1'b0));
      directed.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 200, 32'hFFFF_FFF0,
                                   1'b0));
      directed.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 200, 32'h0000_0300,
                                   1'b0));
      foreach (directed[i]) send_item(directed[i]);
      wait_drained();

      // reset config, loose time steps
      time_ms = 32'd6000;
      run_phase(250, 200, 1'b1);

      // tight dwells and timeout so every fault shows up often
      apply_settings(32'd1000, 32'd5000, 32'd60, 32'd3000, 32'd500, 32'd20, 32'd30,
                     32'd25);
      run_phase(400, 15, 1'b1);

      // everything at zero
      apply_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      run_phase(250, 5, 1'b0);

      // everything at its maximum
      apply_settings(32'h7FFF, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFF, 32'hFFF, 32'hFFFF,
                     32'hFFFF, 32'hFFFF);
      run_phase(250, 5000, 1'b1);

      // random config, wide write data checks truncation to register width
      apply_settings($urandom, $urandom, $urandom_range(0, 5000), $urandom, $urandom,
                     $urandom_range(0, 3000), $urandom_range(0, 3000),
                     $urandom_range(0, 3000));
      run_phase(300, 400, 1'b1);

      // tight settings again, no idling on either side for the last stretch
      apply_settings(32'd2000, 32'd7000, 32'd40, 32'd3500, 32'd300, 32'd12, 32'd18,
                     32'd15);
      run_phase(300, 10, 1'b0);

      if (sb.errors == 0 && sb.pending() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
